### design/timer_min_heap_unit_macros.svh
// assertion macros for the timer heap unit
`ifndef TIMER_MIN_HEAP_UNIT_MACROS_SVH
`define TIMER_MIN_HEAP_UNIT_MACROS_SVH

// property that must hold every clock outside reset
`define TMH_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock
`define TMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tmh_pkg.sv
// types and codes shared by the timer heap unit
package tmh_pkg;

    localparam int ID_BITS  = 5;
    localparam int NUM_IDS  = 32;
    localparam int EXP_BITS = 32;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_ADJUST = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_DECREASED = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]          mode;
        logic [ID_BITS-1:0]  timer_id;
        logic [EXP_BITS-1:0] expire;
        logic [EXP_BITS-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic [ID_BITS-1:0] fired_id;
        logic               fired;
        logic [2:0]         status;
        logic [5:0]         entry_count;
        logic               last;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_PUT,
        S_ADJ_RD,
        S_ADJ_CMP,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_EMIT,
        S_POP_RD,
        S_POP_WAIT,
        S_SD_RDL,
        S_SD_RDR,
        S_SD_CMP,
        S_SD_MOVE,
        S_SD_PUT,
        S_FIRE_RD,
        S_FIRE_EMIT,
        S_STATUS
    } t_state;

endpackage

### design/tmh_ram.sv
// generic single write, single read ram with registered read
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/timer_min_heap_unit.sv
// top level of the timer heap unit: sequencer, heap memory and id tables
//
// A binary min-heap of up to CAPACITY timers, keyed by expiry, with a slot
// table per timer id. One transaction is taken at a time; o_in_ready is low
// while it is worked. The heap entries (id, live bit, expiry) sit in one ram
// with a single registered read port, and the one expiry comparator is shared
// by all sifts. An add sifts the new entry up from the end of the heap and an
// accepted adjust sifts its entry down; a delete clears the entry's live bit,
// and the dead entry stays until a tick pops it. A tick pops each expired entry,
// moving the last entry to the root and sifting it down. Fired ids are parked
// in a small ram during the tick and sent afterwards, so that every result
// carries the entry count after the whole step. Each fired timer is a result
// transaction of its own, and a final status transaction with last set closes
// every input. A stalled receiver holds the sequencer in the state that loads a
// result. The output register lets the sequencer run while a result waits only
// up to the next result. No clearing pass after reset.
module timer_min_heap_unit
    import tmh_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter int TIME_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);
    `include "timer_min_heap_unit_macros.svh"

    localparam int SB = $clog2(CAPACITY);       // slot index bits
    localparam int CB = $clog2(CAPACITY + 1);   // count bits
    // time bits actually kept, the input fields are no wider than EXP_BITS
    localparam int TB = (TIME_BITS < EXP_BITS) ? TIME_BITS : EXP_BITS;
    localparam int EW = ID_BITS + 1 + TB;       // ram word
    localparam int FB = $clog2(NUM_IDS + 1);    // fired count bits

    // ram word layout: {id, live, expiry}
    logic           ram_we;
    logic [SB-1:0]  ram_waddr, ram_raddr;
    logic [EW-1:0]  ram_wdata, ram_rdata;
    logic [ID_BITS-1:0] rd_id;
    logic               rd_live;
    logic [TB-1:0]      rd_exp;

    tmh_ram #(.WIDTH(EW), .DEPTH(1 << SB)) u_heap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );
    assign {rd_id, rd_live, rd_exp} = ram_rdata;

    // slot table per id
    logic          slot_we;
    logic [ID_BITS-1:0] slot_wid;
    logic [SB-1:0] slot_wdata, slot_rdata;
    logic [ID_BITS-1:0] slot_rid;
    tmh_ram #(.WIDTH(SB), .DEPTH(NUM_IDS)) u_slot (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_wid),
        .i_wdata(slot_wdata),
        .i_raddr(slot_rid),
        .o_rdata(slot_rdata)
    );

    // fired ids of the running tick, in pop order
    logic               fire_we;
    logic [ID_BITS-1:0] fire_waddr, fire_raddr;
    logic [ID_BITS-1:0] fire_wdata, fire_rdata;
    tmh_ram #(.WIDTH(ID_BITS), .DEPTH(NUM_IDS)) u_fired (
        .i_clk  (i_clk),
        .i_we   (fire_we),
        .i_waddr(fire_waddr),
        .i_wdata(fire_wdata),
        .i_raddr(fire_raddr),
        .o_rdata(fire_rdata)
    );

    t_state r_state, n_state;
    logic [NUM_IDS-1:0] r_present, n_present, r_armed, n_armed;
    logic [CB-1:0]  r_total, n_total;
    t_in_item       r_item, n_item;
    logic [SB-1:0]  r_hole, n_hole, r_child, n_child;
    logic [ID_BITS-1:0] r_tid, n_tid;      // entry being placed
    logic               r_tlive, n_tlive;
    logic [TB-1:0]      r_texp, n_texp;
    logic [ID_BITS-1:0] r_cid, n_cid;      // best child
    logic               r_clive, n_clive;
    logic [TB-1:0]      r_cexp, n_cexp;
    logic [FB-1:0]  r_fcnt, n_fcnt, r_fidx, n_fidx;
    logic [2:0]     r_status, n_status;
    logic           r_ovalid, n_ovalid;
    t_out_item      r_odata, n_odata;

    logic [TB-1:0] in_exp, in_now;
    assign in_exp = i_in_data.expire[TB-1:0];
    assign in_now = i_in_data.now[TB-1:0];

    // shared comparator: a < b
    logic [TB-1:0] cmp_a, cmp_b;
    logic          cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;

    logic [CB:0] left_w, right_w;
    logic [SB-1:0] parent_w;
    assign left_w   = (CB+1)'({r_hole, 1'b1});
    assign right_w  = left_w + (CB+1)'(1);
    assign parent_w = SB'((r_hole - SB'(1)) >> 1);

    logic out_free;
    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_armed   <= '0;
            r_total   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_armed   <= n_armed;
            r_total   <= n_total;
            r_ovalid  <= n_ovalid;
        end
        r_item   <= n_item;
        r_hole   <= n_hole;
        r_child  <= n_child;
        r_tid    <= n_tid;
        r_tlive  <= n_tlive;
        r_texp   <= n_texp;
        r_cid    <= n_cid;
        r_clive  <= n_clive;
        r_cexp   <= n_cexp;
        r_fcnt   <= n_fcnt;
        r_fidx   <= n_fidx;
        r_status <= n_status;
        r_odata  <= n_odata;
    end

    logic [ID_BITS-1:0] id_w;
    assign id_w = r_item.timer_id;

    always_comb begin
        n_state = r_state; n_present = r_present; n_armed = r_armed;
        n_total = r_total; n_item = r_item; n_hole = r_hole; n_child = r_child;
        n_tid = r_tid; n_tlive = r_tlive; n_texp = r_texp;
        n_cid = r_cid; n_clive = r_clive; n_cexp = r_cexp;
        n_fcnt = r_fcnt; n_fidx = r_fidx;
        n_status = r_status;
        n_ovalid = r_ovalid && !i_out_ready;
        n_odata = r_odata;
        ram_we = 1'b0; ram_waddr = r_hole; ram_wdata = {r_tid, r_tlive, r_texp};
        ram_raddr = r_hole;
        slot_we = 1'b0; slot_wid = r_tid; slot_wdata = r_hole; slot_rid = id_w;
        fire_we = 1'b0; fire_waddr = ID_BITS'(r_fcnt); fire_wdata = r_tid;
        fire_raddr = ID_BITS'(r_fidx);
        cmp_a = r_texp; cmp_b = rd_exp;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                slot_rid = i_in_data.timer_id;
                if (i_in_valid) begin
                    n_item = i_in_data;
                    n_item.expire = EXP_BITS'(in_exp);
                    n_item.now    = EXP_BITS'(in_now);
                    n_status = ST_OK;
                    n_fcnt = '0;
                    n_fidx = '0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (t_mode'(r_item.mode))
                    MODE_ADD: begin
                        if (r_present[id_w]) begin
                            n_status = ST_DUPLICATE; n_state = S_STATUS;
                        end else if (r_total >= CB'(CAPACITY)) begin
                            n_status = ST_FULL; n_state = S_STATUS;
                        end else begin
                            n_hole = SB'(r_total);
                            n_total = r_total + CB'(1);
                            n_tid = id_w; n_tlive = 1'b1;
                            n_texp = r_item.expire[TB-1:0];
                            n_present[id_w] = 1'b1; n_armed[id_w] = 1'b1;
                            n_state = S_ADD_RD;
                        end
                    end
                    MODE_DELETE: begin
                        if (!r_present[id_w]) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            n_present[id_w] = 1'b0; n_armed[id_w] = 1'b0;
                            if (CB'(slot_rdata) < r_total) begin
                                // read the entry back to clear its live bit
                                n_hole = slot_rdata;
                                n_state = S_ADJ_RD;
                            end
                        end
                        if (n_state == S_DISPATCH) n_state = S_STATUS;
                    end
                    MODE_ADJUST: begin
                        if (!r_present[id_w] || CB'(slot_rdata) >= r_total) begin
                            n_status = ST_NOT_FOUND; n_state = S_STATUS;
                        end else begin
                            n_hole = slot_rdata; n_state = S_ADJ_RD;
                        end
                    end
                    default: begin
                        n_state = S_TICK_RD;
                    end
                endcase
            end
            S_ADD_RD: begin
                if (r_hole == '0) begin
                    n_state = S_ADD_PUT;
                end else begin
                    ram_raddr = parent_w; n_state = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                // parent at parent_w is in rd; move it down if texp < parent
                cmp_a = r_texp; cmp_b = rd_exp;
                if (cmp_lt) begin
                    ram_we = 1'b1; ram_waddr = r_hole;
                    ram_wdata = ram_rdata;
                    if (rd_live) begin
                        slot_we = 1'b1; slot_wid = rd_id; slot_wdata = r_hole;
                    end
                    n_hole = parent_w;
                    n_state = S_ADD_RD;
                end else begin
                    n_state = S_ADD_PUT;
                end
            end
            S_ADD_PUT: begin
                ram_we = 1'b1;
                if (r_tlive) slot_we = 1'b1;
                n_state = S_STATUS;
            end
            S_ADJ_RD: begin
                ram_raddr = r_hole; n_state = S_ADJ_CMP;
            end
            S_ADJ_CMP: begin
                n_tid = rd_id; n_tlive = rd_live; n_texp = rd_exp;
                if (t_mode'(r_item.mode) == MODE_DELETE) begin
                    ram_we = 1'b1;
                    ram_wdata = {rd_id, 1'b0, rd_exp};
                    n_state = S_STATUS;
                end else begin
                    cmp_a = r_item.expire[TB-1:0]; cmp_b = rd_exp;
                    if (cmp_lt) begin
                        n_status = ST_DECREASED; n_state = S_STATUS;
                    end else begin
                        n_texp = r_item.expire[TB-1:0];
                        n_state = S_SD_RDL;
                    end
                end
            end
            S_TICK_RD: begin
                ram_raddr = '0;
                if (r_total == '0) begin
                    n_state = (r_fcnt != '0) ? S_FIRE_RD : S_STATUS;
                end else begin
                    n_state = S_TICK_CHK;
                end
            end
            S_TICK_CHK: begin
                cmp_a = r_item.now[TB-1:0]; cmp_b = rd_exp;
                if (cmp_lt) begin
                    n_state = (r_fcnt != '0) ? S_FIRE_RD : S_STATUS;
                end else begin
                    n_tid = rd_id; n_tlive = rd_live;
                    n_state = S_TICK_EMIT;
                end
            end
            S_TICK_EMIT: begin
                if (r_tlive) begin
                    if (r_armed[r_tid]) begin
                        // park the fired id until the final entry count is known
                        fire_we = 1'b1;
                        n_fcnt = r_fcnt + FB'(1);
                    end
                    n_present[r_tid] = 1'b0; n_armed[r_tid] = 1'b0;
                end
                n_state = S_POP_RD;
            end
            S_POP_RD: begin
                n_total = r_total - CB'(1);
                ram_raddr = SB'(r_total - CB'(1));
                n_hole = '0;
                n_state = (r_total == CB'(1)) ? S_TICK_RD : S_POP_WAIT;
            end
            S_POP_WAIT: begin
                n_tid = rd_id; n_tlive = rd_live; n_texp = rd_exp;
                n_state = S_SD_RDL;
            end
            S_SD_RDL: begin
                if (left_w >= (CB+1)'(r_total)) begin
                    n_state = S_SD_PUT;
                end else begin
                    ram_raddr = SB'(left_w); n_child = SB'(left_w);
                    n_state = S_SD_RDR;
                end
            end
            S_SD_RDR: begin
                n_cid = rd_id; n_clive = rd_live; n_cexp = rd_exp;
                ram_raddr = SB'(right_w);
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                cmp_a = rd_exp; cmp_b = r_cexp;
                if (right_w < (CB+1)'(r_total) && cmp_lt) begin
                    n_cid = rd_id; n_clive = rd_live; n_cexp = rd_exp;
                    n_child = SB'(right_w);
                end
                n_state = S_SD_MOVE;
            end
            S_SD_MOVE: begin
                cmp_a = r_cexp; cmp_b = r_texp;
                if (cmp_lt) begin
                    ram_we = 1'b1; ram_waddr = r_hole;
                    ram_wdata = {r_cid, r_clive, r_cexp};
                    if (r_clive) begin
                        slot_we = 1'b1; slot_wid = r_cid; slot_wdata = r_hole;
                    end
                    n_hole = r_child;
                    n_state = S_SD_RDL;
                end else begin
                    n_state = S_SD_PUT;
                end
            end
            S_SD_PUT: begin
                ram_we = 1'b1;
                if (r_tlive) slot_we = 1'b1;
                n_state = (t_mode'(r_item.mode) == MODE_TICK) ? S_TICK_RD : S_STATUS;
            end
            S_FIRE_RD: begin
                // fired id at r_fidx arrives next cycle
                n_state = S_FIRE_EMIT;
            end
            S_FIRE_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata = '{fired_id: fire_rdata, fired: 1'b1, status: ST_OK,
                                entry_count: 6'(r_total), last: 1'b0};
                    n_fidx = r_fidx + FB'(1);
                    n_state = (r_fidx + FB'(1) == r_fcnt) ? S_STATUS : S_FIRE_RD;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata = '{fired_id: '0, fired: 1'b0, status: r_status,
                                entry_count: 6'(r_total), last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // the heap never holds more than its capacity
    `TMH_ASSERT_ALWAYS(a_total_cap, i_clk, i_rst_n, r_total <= CB'(CAPACITY), "heap overfull")
    // a new transaction is only taken in the idle state
    `TMH_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_DISPATCH, "accept did not start work")
    // a result marked last is never a fired result
    `TMH_ASSERT_ALWAYS(a_last_not_fired, i_clk, i_rst_n,
        !(o_out_valid && o_out_data.last && o_out_data.fired), "fired result marked last")
endmodule

### test/testbench.sv
// testbench for the timer heap unit: directed and random transactions against a scoreboard
`timescale 1ns / 100ps

module testbench;
    import tmh_pkg::*;

    localparam int HEAP_SLOTS  = 32;
    localparam int STALL_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    timer_min_heap_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // shadow copy of the heap and the id tables
    logic [4:0]  heap_id_q   [HEAP_SLOTS];
    logic [31:0] heap_exp_q  [HEAP_SLOTS];
    logic        heap_live_q [HEAP_SLOTS];
    logic [4:0]  slot_tab    [NUM_IDS];
    logic        id_in_heap  [NUM_IDS];
    logic        id_armed_q  [NUM_IDS];
    int          heap_size;

    // results still owed by the unit, oldest first
    t_out_item   owed_results[$];

    int          error_count;
    int          idle_cycles;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    logic        receiver_hold;
    logic [31:0] clock_secs;

    // --------------------------------------------------------------------
    // heap shadow helpers
    // --------------------------------------------------------------------
    function automatic void place(int slot, logic [4:0] id, logic [31:0] exp_t, logic live);
        heap_id_q[slot]   = id;
        heap_exp_q[slot]  = exp_t;
        heap_live_q[slot] = live;
        if (live)
            slot_tab[id] = slot[4:0];
    endfunction

    function automatic void sink_from(int start);
        int          hole;
        int          child;
        logic [4:0]  tid;
        logic [31:0] texp;
        logic        tlive;
        hole  = start;
        tid   = heap_id_q[hole];
        texp  = heap_exp_q[hole];
        tlive = heap_live_q[hole];
        while (2 * hole + 1 < heap_size) begin
            child = 2 * hole + 1;
            if (child + 1 < heap_size && heap_exp_q[child + 1] < heap_exp_q[child])
                child++;
            if (heap_exp_q[child] < texp) begin
                place(hole, heap_id_q[child], heap_exp_q[child], heap_live_q[child]);
                hole = child;
            end else begin
                break;
            end
        end
        place(hole, tid, texp, tlive);
    endfunction

    function automatic t_out_item result_of(logic [4:0] id, logic fired, t_status st,
                                            logic last);
        t_out_item r;
        r.fired_id    = id;
        r.fired       = fired;
        r.status      = st;
        r.entry_count = 6'(heap_size);
        r.last        = last;
        return r;
    endfunction

    // works out every result of one accepted transaction and queues it
    function automatic void forecast_timer_results(t_in_item it);
        t_status     st;
        int          hole;
        int          parent;
        int          s;
        logic [4:0]  tid;
        logic [4:0]  fired_ids[$];
        st = ST_OK;
        case (t_mode'(it.mode))
            MODE_ADD: begin
                if (id_in_heap[it.timer_id]) begin
                    st = ST_DUPLICATE;
                end else if (heap_size >= HEAP_SLOTS) begin
                    st = ST_FULL;
                end else begin
                    hole = heap_size;
                    heap_size++;
                    while (hole > 0) begin
                        parent = (hole - 1) / 2;
                        if (heap_exp_q[parent] <= it.expire)
                            break;
                        place(hole, heap_id_q[parent], heap_exp_q[parent],
                              heap_live_q[parent]);
                        hole = parent;
                    end
                    place(hole, it.timer_id, it.expire, 1'b1);
                    id_in_heap[it.timer_id] = 1'b1;
                    id_armed_q[it.timer_id] = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (!id_in_heap[it.timer_id]) begin
                    st = ST_NOT_FOUND;
                end else begin
                    s = slot_tab[it.timer_id];
                    if (s < heap_size)
                        heap_live_q[s] = 1'b0;
                    id_in_heap[it.timer_id] = 1'b0;
                    id_armed_q[it.timer_id] = 1'b0;
                end
            end
            MODE_ADJUST: begin
                // slot table is only consulted for ids that are present
                if (!id_in_heap[it.timer_id] || slot_tab[it.timer_id] >= heap_size) begin
                    st = ST_NOT_FOUND;
                end else begin
                    s = slot_tab[it.timer_id];
                    if (it.expire < heap_exp_q[s]) begin
                        st = ST_DECREASED;
                    end else begin
                        heap_exp_q[s] = it.expire;
                        sink_from(s);
                    end
                end
            end
            default: begin
                while (heap_size > 0 && heap_exp_q[0] <= it.now) begin
                    tid = heap_id_q[0];
                    if (heap_live_q[0]) begin
                        if (id_armed_q[tid] && fired_ids.size() < 32)
                            fired_ids.push_back(tid);
                        id_in_heap[tid] = 1'b0;
                        id_armed_q[tid] = 1'b0;
                    end
                    heap_size--;
                    if (heap_size > 0) begin
                        place(0, heap_id_q[heap_size], heap_exp_q[heap_size],
                              heap_live_q[heap_size]);
                        sink_from(0);
                    end
                end
            end
        endcase
        // entry count is taken after the whole step, so fired results wait till here
        foreach (fired_ids[k])
            owed_results.push_back(result_of(fired_ids[k], 1'b1, ST_OK, 1'b0));
        owed_results.push_back(result_of(5'd0, 1'b0, st, 1'b1));
    endfunction

    // --------------------------------------------------------------------
    // sender: drives at the falling edge, sees acceptance at the rising edge
    // --------------------------------------------------------------------
    task automatic offer_timer_op(t_mode m, logic [4:0] id, logic [31:0] exp_t,
                                  logic [31:0] now_t);
        t_in_item it;
        it.mode     = m;
        it.timer_id = id;
        it.expire   = exp_t;
        it.now      = now_t;
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        forecast_timer_results(it);
    endtask

    // lowers valid and waits until every owed result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (owed_results.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    // random transaction, mostly well formed against a slowly moving clock
    task automatic random_timer_op();
        int          pick;
        logic [4:0]  id;
        logic [31:0] exp_t;
        logic [31:0] now_t;
        pick  = $urandom_range(99);
        id    = 5'($urandom_range(31));
        now_t = $urandom;
        exp_t = ($urandom_range(9) == 0) ? $urandom : clock_secs + $urandom_range(60);
        if (pick < 40) begin
            offer_timer_op(MODE_ADD, id, exp_t, now_t);
        end else if (pick < 55) begin
            offer_timer_op(MODE_DELETE, id, exp_t, now_t);
        end else if (pick < 75) begin
            if (id_in_heap[id] && $urandom_range(3) != 0)
                exp_t = heap_exp_q[slot_tab[id]] + $urandom_range(40) - 8;
            offer_timer_op(MODE_ADJUST, id, exp_t, now_t);
        end else begin
            clock_secs += $urandom_range(12);
            now_t = ($urandom_range(19) == 0) ? $urandom : clock_secs;
            offer_timer_op(MODE_TICK, id, exp_t, now_t);
        end
    endtask

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------
    task automatic test_directed_cases();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        offer_timer_op(MODE_TICK, 5'd0, 32'd0, 32'hFFFF_FFFF);        // empty heap
        offer_timer_op(MODE_DELETE, 5'd7, 32'd0, 32'd0);              // missing id
        offer_timer_op(MODE_ADJUST, 5'd7, 32'd5, 32'd0);              // missing id
        offer_timer_op(MODE_ADD, 5'd0, 32'd0, 32'd0);
        offer_timer_op(MODE_ADD, 5'd31, 32'hFFFF_FFFF, 32'd0);
        offer_timer_op(MODE_ADD, 5'd31, 32'd3, 32'd0);                // duplicate
        offer_timer_op(MODE_ADD, 5'd10, 32'd100, 32'd0);
        offer_timer_op(MODE_ADD, 5'd11, 32'd100, 32'd0);              // equal expiry tie
        offer_timer_op(MODE_ADJUST, 5'd10, 32'd99, 32'd0);            // decreased expiry
        offer_timer_op(MODE_ADJUST, 5'd10, 32'd100, 32'd0);           // equal is accepted
        offer_timer_op(MODE_ADJUST, 5'd0, 32'd200, 32'd0);            // sinks down
        offer_timer_op(MODE_DELETE, 5'd11, 32'd0, 32'd0);             // leaves a dead entry
        offer_timer_op(MODE_ADD, 5'd11, 32'd50, 32'd0);               // re-add while dead entry remains
        offer_timer_op(MODE_TICK, 5'd0, 32'd0, 32'd99);
        offer_timer_op(MODE_TICK, 5'd0, 32'd0, 32'd100);              // dead entry popped
        offer_timer_op(MODE_TICK, 5'd0, 32'd0, 32'hFFFF_FFFF);        // flush everything
        drain_results();
    endtask

    // fills the heap, then a deleted id's dead entry keeps it full
    task automatic test_heap_full();
        for (int i = 0; i < NUM_IDS; i++)
            offer_timer_op(MODE_ADD, 5'(i), 32'(1000 + $urandom_range(50)), 32'd0);
        offer_timer_op(MODE_DELETE, 5'd4, 32'd0, 32'd0);
        offer_timer_op(MODE_ADD, 5'd4, 32'd1, 32'd0);                 // heap full
        offer_timer_op(MODE_TICK, 5'd0, 32'd0, 32'd2000);             // many fired results
        drain_results();
    endtask

    task automatic test_random_phase(int n, int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n) random_timer_op();
        drain_results();
    endtask

    // receiver holds off for a long stretch while transactions keep coming
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        fork
            begin
                receiver_hold = 1'b1;
                repeat (400) @(negedge i_clk);
                receiver_hold = 1'b0;
            end
        join_none
        repeat (30) random_timer_op();
        drain_results();
    endtask

    // --------------------------------------------------------------------
    // receiver ready, result checking and watchdog
    // --------------------------------------------------------------------
    always @(negedge i_clk)
        i_out_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_out_data.fired_id !== want.fired_id)
                    $display("%0t: fired_id expected %0d actual %0d", $time,
                             want.fired_id, o_out_data.fired_id);
                if (o_out_data.fired !== want.fired)
                    $display("%0t: fired expected %0d actual %0d", $time,
                             want.fired, o_out_data.fired);
                if (o_out_data.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_out_data.status);
                if (o_out_data.entry_count !== want.entry_count)
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             want.entry_count, o_out_data.entry_count);
                if (o_out_data.last !== want.last)
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, o_out_data.last);
                if (o_out_data !== want)
                    error_count++;
            end
        end
    end

    // any transaction on either side resets the stall count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** timer_min_heap_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        heap_size     = 0;
        clock_secs    = 32'd0;
        receiver_hold = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < NUM_IDS; i++) begin
            id_in_heap[i] = 1'b0;
            id_armed_q[i] = 1'b0;
        end
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_heap_full();
        test_random_phase(65, 0, 0);
        test_random_phase(65, 54, 0);
        test_random_phase(65, 0, 54);
        test_random_phase(40, 6, 6);
        test_backpressure();

        repeat (50) @(posedge i_clk);
        if (error_count == 0 && owed_results.size() == 0)
            $display("** timer_min_heap_unit: PASSED **");
        else
            $display("** timer_min_heap_unit: FAILED **");
        $finish;
    end

endmodule
